// File: src/refcounted_page_allocator_defines.svh
// assertion macros for the page allocator
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define RPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rpa_pkg.sv
// shared types, constants and init functions for the page allocator
// no dependencies
package rpa_pkg;

  localparam int PAGES           = 512;
  localparam int FIRST_USER_PAGE = 256;
  localparam int EXCLUDED_PAGE   = 184;
  localparam int PAGE_BYTES      = 4096;

  localparam int PN_W  = 9;   // page field width
  localparam int RB_W  = 16;  // request size field width
  localparam int CNT_W = 8;
  localparam int PG_W  = $clog2(PAGES);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_SHARE   = 2'd2,
    CMD_NONE    = 2'd3
  } rpa_cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_IN_USE = 3'd3,
    ST_SATURATED  = 3'd4
  } rpa_status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } rpa_state_e;

  // free-list link of page p right after reset
  function automatic logic [PG_W-1:0] init_link(logic [PG_W-1:0] p);
    int pi;
    int q;
    pi = int'(p);
    q  = pi - 1;
    if (q == EXCLUDED_PAGE) q = q - 1;
    if (pi < FIRST_USER_PAGE || pi == EXCLUDED_PAGE || q < FIRST_USER_PAGE) begin
      return '0;
    end
    return PG_W'(q);
  endfunction

  // highest user page, or null when there is none
  function automatic int head_init();
    int h;
    h = PAGES - 1;
    if (h == EXCLUDED_PAGE) h = h - 1;
    if (h < FIRST_USER_PAGE) h = 0;
    return h;
  endfunction

  localparam logic [PG_W-1:0] HEAD_RST = PG_W'(head_init());

endpackage

// File: src/rpa_req_if.sv
// command channel of the page allocator
// depends on rpa_pkg for field widths
interface rpa_req_if
  import rpa_pkg::*;
;
  logic            valid;
  logic            ready;
  logic [1:0]      cmd;
  logic [PN_W-1:0] page_number;
  logic [RB_W-1:0] req_bytes;

  modport source (output valid, output cmd, output page_number, output req_bytes,
                  input ready);
  modport sink   (input valid, input cmd, input page_number, input req_bytes,
                  output ready);
endinterface

// File: src/rpa_rsp_if.sv
// result channel of the page allocator
// depends on rpa_pkg for field widths
interface rpa_rsp_if
  import rpa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [PN_W-1:0]  page_out;
  logic [CNT_W-1:0] count_out;

  modport source (output valid, output status, output page_out, output count_out,
                  input ready);
  modport sink   (input valid, input status, input page_out, input count_out,
                  output ready);
endinterface

// File: src/refcounted_page_allocator.sv
// Page allocator with a LIFO free list and an 8-bit reference count per page.
// After reset the block runs an init pass that writes every entry of the link
// and count memories; no command is taken during it.
// Each command then has a read phase (link memory at the list head, count memory
// at the given page) and a phase that modifies and writes back; no new command
// is taken until the last one has done its write-back. The result sits in
// an output register, so the next command is taken while a result still
// waits; its write-back cycle waits until that result has been taken.
// Depends on rpa_pkg, rpa_req_if, rpa_rsp_if, rpa_ram and the defines header.
`include "refcounted_page_allocator_defines.svh"

module refcounted_page_allocator
  import rpa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  rpa_req_if.sink   in_i,
  rpa_rsp_if.source out_o
);

  // control state
  rpa_state_e        state_q, state_d;
  logic [PG_W-1:0]   clr_idx_q;
  logic [PG_W-1:0]   head_q, head_d;

  // command captured at accept
  rpa_cmd_e          op_q;
  logic [PN_W-1:0]   pg_q;
  logic              big_q;   // request larger than a page
  logic              oor_q;   // page outside the store

  // output register
  logic              out_valid_q;
  rpa_status_e       out_status_q, res_status;
  logic [PN_W-1:0]   out_page_q, res_page;
  logic [CNT_W-1:0]  out_count_q, res_count;

  // memory ports
  logic              nf_we, nf_re;
  logic [PG_W-1:0]   nf_waddr;
  logic [PG_W-1:0]   nf_wdata, nf_rdata;
  logic              cnt_we, cnt_re;
  logic [PG_W-1:0]   cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  // write-back side requests
  logic              ex_nf_we, ex_cnt_we;
  logic [CNT_W-1:0]  ex_cnt_wdata;

  logic              in_acc;
  logic              fire;
  logic              clearing;
  logic [PG_W-1:0]   pg_addr;

  assign in_acc  = in_i.valid && in_i.ready;
  assign pg_addr = pg_q[PG_W-1:0];

  // ---------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_idx_q == PG_W'(PAGES - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  if (fire) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_i.ready = 1'b0;
    clearing   = 1'b0;
    fire       = 1'b0;
    case (state_q)
      S_CLEAR: clearing = 1'b1;
      S_IDLE:  in_i.ready = 1'b1;
      // write back only when the output slot is free or being emptied
      S_EXEC:  fire = !out_valid_q || out_o.ready;
      default: clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_idx_q <= '0;
      head_q    <= HEAD_RST;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      if (clearing) clr_idx_q <= clr_idx_q + 1'b1;
    end
  end

  // capture the command; the size and range checks are resolved here
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= rpa_cmd_e'(in_i.cmd);
      pg_q  <= in_i.page_number;
      big_q <= ({1'b0, in_i.req_bytes} > (RB_W + 1)'(PAGE_BYTES));
      oor_q <= (int'(in_i.page_number) >= PAGES);
    end
  end

  // ---------------------------------------------------------------
  // read phase: issued on accept
  // ---------------------------------------------------------------
  assign nf_re  = in_acc && (rpa_cmd_e'(in_i.cmd) == CMD_ALLOC);
  assign cnt_re = in_acc;

  // ---------------------------------------------------------------
  // modify phase
  // ---------------------------------------------------------------
  always_comb begin
    res_status   = ST_OK;
    res_page     = '0;
    res_count    = '0;
    head_d       = head_q;
    ex_nf_we     = 1'b0;
    ex_cnt_we    = 1'b0;
    ex_cnt_wdata = '0;
    case (op_q)
      CMD_ALLOC: begin
        if (big_q) begin
          res_status = ST_TOO_LARGE;
        end else if (head_q == '0) begin
          res_status = ST_EMPTY;
        end else begin
          // pop the head and give it one reference
          res_page     = PN_W'(head_q);
          res_count    = CNT_W'(1);
          ex_cnt_we    = fire;
          ex_cnt_wdata = CNT_W'(1);
          if (fire) head_d = nf_rdata;
        end
      end
      CMD_RELEASE, CMD_SHARE: begin
        if (pg_q == '0) begin
          res_status = ST_OK;   // null page, nothing to do
        end else if (oor_q || cnt_rdata == '0) begin
          res_status = ST_NOT_IN_USE;
          res_page   = pg_q;
        end else if (op_q == CMD_RELEASE) begin
          res_page     = pg_q;
          res_count    = cnt_rdata - 1'b1;
          ex_cnt_we    = fire;
          ex_cnt_wdata = cnt_rdata - 1'b1;
          // last reference gone: push the page back on the list
          if (cnt_rdata == CNT_W'(1)) begin
            ex_nf_we = fire;
            if (fire) head_d = pg_addr;
          end
        end else if (cnt_rdata == CNT_MAX) begin
          res_status = ST_SATURATED;
          res_page   = pg_q;
          res_count  = CNT_MAX;
        end else begin
          res_page     = pg_q;
          res_count    = cnt_rdata + 1'b1;
          ex_cnt_we    = fire;
          ex_cnt_wdata = cnt_rdata + 1'b1;
        end
      end
      default: res_status = ST_OK;  // unused command code
    endcase
  end

  // write ports: the init pass owns them until it is done
  always_comb begin
    if (clearing) begin
      nf_we     = 1'b1;
      nf_waddr  = clr_idx_q;
      nf_wdata  = init_link(clr_idx_q);
      cnt_we    = 1'b1;
      cnt_waddr = clr_idx_q;
      cnt_wdata = '0;
    end else begin
      nf_we     = ex_nf_we;
      nf_waddr  = pg_addr;
      nf_wdata  = head_q;
      cnt_we    = ex_cnt_we;
      cnt_waddr = (op_q == CMD_ALLOC) ? head_q : pg_addr;
      cnt_wdata = ex_cnt_wdata;
    end
  end

  rpa_ram #(
    .WIDTH (PG_W),
    .DEPTH (PAGES)
  ) u_next_free (
    .clk_i   (clk_i),
    .we_i    (nf_we),
    .waddr_i (nf_waddr),
    .wdata_i (nf_wdata),
    .re_i    (nf_re),
    .raddr_i (head_q),
    .rdata_o (nf_rdata)
  );

  rpa_ram #(
    .WIDTH (CNT_W),
    .DEPTH (PAGES)
  ) u_ref_count (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (in_i.page_number[PG_W-1:0]),
    .rdata_o (cnt_rdata)
  );

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q <= res_status;
      out_page_q   <= res_page;
      out_count_q  <= res_count;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.page_out  = out_page_q;
  assign out_o.count_out = out_count_q;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // the list head is null or a user page, never the excluded one
  `RPA_ASSERT_NOW(a_head_legal, 1'b1, (head_q == '0) || ((int'(head_q) >= FIRST_USER_PAGE) && (int'(head_q) != EXCLUDED_PAGE)), "list head is not a user page")
  // no command is taken while the init pass runs
  `RPA_ASSERT_NOW(a_no_accept_in_clear, clearing, !in_i.ready, "command taken during init pass")
  // write-back never overwrites a result that is still waiting
  `RPA_ASSERT_NOW(a_no_overrun, fire, !out_valid_q || out_o.ready, "result overwritten")
  // an accepted command is always followed by its write-back cycle
  `RPA_ASSERT_NXT(a_accept_exec, in_acc, state_q == S_EXEC, "accept without write-back phase")

endmodule

// File: src/rpa_ram.sv
// single-port-write, single-port-read ram with registered read data
// no dependencies
module rpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: dv/refcounted_page_allocator_checker.sv
// checker for the page allocator: watches both channels, predicts each result
// from its own copy of the free list and counts, and counts mismatches
// depends on rpa_pkg
module refcounted_page_allocator_checker
  import rpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  logic             cmd_ready_i,
  input  logic [1:0]       cmd_i,
  input  logic [PN_W-1:0]  page_number_i,
  input  logic [RB_W-1:0]  req_bytes_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  logic [2:0]       status_i,
  input  logic [PN_W-1:0]  page_out_i,
  input  logic [CNT_W-1:0] count_out_i,
  output int               error_count_o,
  output logic             drained_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rpa_status_e      status;
    logic [PN_W-1:0]  page;
    logic [CNT_W-1:0] count;
  } page_result_t;

  logic [PN_W-1:0]  free_head;
  logic [PN_W-1:0]  free_link [PAGES];
  logic [CNT_W-1:0] ref_cnt   [PAGES];
  page_result_t     expected_results [$];

  // every user page on the list, highest at the head, all counts zero
  function automatic void reset_page_state();
    logic [PN_W-1:0] prev;
    prev = '0;
    for (int p = 0; p < PAGES; p++) begin
      ref_cnt[p]   = '0;
      free_link[p] = '0;
    end
    for (int p = FIRST_USER_PAGE; p < PAGES; p++) begin
      if (p != EXCLUDED_PAGE) begin
        free_link[p] = prev;
        prev         = PN_W'(p);
      end
    end
    free_head = prev;
  endfunction

  function automatic page_result_t apply_page_cmd(rpa_cmd_e op, logic [PN_W-1:0] pg,
                                                  logic [RB_W-1:0] nbytes);
    page_result_t     r;
    logic [PN_W-1:0]  taken;
    logic [CNT_W-1:0] c;
    r.status = ST_OK;
    r.page   = '0;
    r.count  = '0;
    case (op)
      CMD_ALLOC: begin
        taken = free_head;
        if (int'(nbytes) > PAGE_BYTES) begin
          r.status = ST_TOO_LARGE;
        end else if (taken == '0 || int'(taken) >= PAGES) begin
          r.status = ST_EMPTY;
        end else begin
          free_head      = free_link[taken];
          ref_cnt[taken] = CNT_W'(1);
          r.page         = taken;
          r.count        = CNT_W'(1);
        end
      end
      CMD_RELEASE, CMD_SHARE: begin
        if (pg != '0) begin
          r.page = pg;
          c      = ref_cnt[pg];
          if (int'(pg) >= PAGES || c == '0) begin
            r.status = ST_NOT_IN_USE;
          end else if (op == CMD_RELEASE) begin
            c           = c - 1'b1;
            ref_cnt[pg] = c;
            // last reference gone: page goes back on top of the list
            if (c == '0) begin
              free_link[pg] = free_head;
              free_head     = pg;
            end
            r.count = c;
          end else if (c == CNT_MAX) begin
            r.status = ST_SATURATED;
            r.count  = CNT_MAX;
          end else begin
            c           = c + 1'b1;
            ref_cnt[pg] = c;
            r.count     = c;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t want;
    if (!rst_ni) begin
      reset_page_state();
      expected_results.delete();
      error_count_o = 0;
    end else begin
      // result side first so a word is never matched against its own command
      if (res_valid_i && res_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word: status %0d page %0d count %0d",
                   $time, status_i, page_out_i, count_out_i);
          error_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status || page_out_i !== want.page ||
              count_out_i !== want.count) begin
            $display("%0t: mismatch: expected status %0d page %0d count %0d, got status %0d page %0d count %0d",
                     $time, want.status, want.page, want.count,
                     status_i, page_out_i, count_out_i);
            error_count_o++;
          end
        end
      end
      if (cmd_valid_i && cmd_ready_i) begin
        expected_results.push_back(apply_page_cmd(rpa_cmd_e'(cmd_i), page_number_i,
                                                  req_bytes_i));
      end
    end
    drained_o = (expected_results.size() == 0);
  end

endmodule

// File: dv/refcounted_page_allocator_tb.sv
// top of the page allocator testbench: clock, reset, command stimulus,
// result back-pressure and the verdict; depends on rpa_pkg, the two channel
// interfaces, the allocator and refcounted_page_allocator_checker
module refcounted_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpa_pkg::*;

  localparam logic [PN_W-1:0] TOP_PAGE = PN_W'(PAGES - 1);
  localparam int FILL_ALLOCS  = 262;  // more good allocations than user pages
  localparam int MIXED_WORDS  = 700;
  localparam int PHASE_WORDS  = 64;   // words per idling phase
  localparam int DRAIN_CYCLES = 16;

  logic clk_i;
  logic rst_ni;
  int   idle_pct;    // chance in percent that the sender idles a cycle
  int   stall_pct;   // chance in percent that the receiver stalls a cycle
  int   words_sent;
  int   error_count;
  logic drained;

  rpa_req_if cmd_if ();
  rpa_rsp_if res_if ();

  refcounted_page_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  refcounted_page_allocator_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_if.valid),
    .cmd_ready_i   (cmd_if.ready),
    .cmd_i         (cmd_if.cmd),
    .page_number_i (cmd_if.page_number),
    .req_bytes_i   (cmd_if.req_bytes),
    .res_valid_i   (res_if.valid),
    .res_ready_i   (res_if.ready),
    .status_i      (res_if.status),
    .page_out_i    (res_if.page_out),
    .count_out_i   (res_if.count_out),
    .error_count_o (error_count),
    .drained_o     (drained)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: ready redrawn every falling edge
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // present one command word at a falling edge and hold it until taken;
  // returns at the falling edge after the handshake with valid still high
  task automatic send_word(input rpa_cmd_e op, input logic [PN_W-1:0] pg,
                           input logic [RB_W-1:0] nbytes);
    while ($urandom_range(99) < idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= op;
    cmd_if.page_number <= pg;
    cmd_if.req_bytes   <= nbytes;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
    // rotate through the idling phases: none, sender gaps, receiver
    // stalls, both
    if (words_sent % PHASE_WORDS == 0) begin
      case ((words_sent / PHASE_WORDS) % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 77;
        end
        default: begin
          idle_pct  = 35;
          stall_pct = 35;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    int              pick;
    logic [PN_W-1:0] sat_page;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.cmd         = CMD_NONE;
    cmd_if.page_number = '0;
    cmd_if.req_bytes   = '0;
    idle_pct           = 0;
    stall_pct          = 0;
    words_sent         = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    // the block clears its memories first; send_word simply waits on ready

    // directed: size limits, null page, free pages, reuse of a released page
    send_word(CMD_ALLOC, '0, '0);                            // zero bytes, takes top page
    send_word(CMD_ALLOC, TOP_PAGE, RB_W'(PAGE_BYTES));       // exactly one page
    send_word(CMD_ALLOC, '0, RB_W'(PAGE_BYTES + 1));         // one byte too many
    send_word(CMD_ALLOC, TOP_PAGE, '1);                      // largest size field
    send_word(CMD_ALLOC, '0, RB_W'(1));
    send_word(CMD_SHARE, TOP_PAGE, '0);                      // count goes to two
    send_word(CMD_RELEASE, TOP_PAGE, '1);
    send_word(CMD_RELEASE, TOP_PAGE, '0);                    // last reference, back on list
    send_word(CMD_RELEASE, TOP_PAGE, '0);                    // release of a free page
    send_word(CMD_SHARE, TOP_PAGE, '0);                      // share of a free page
    send_word(CMD_RELEASE, '0, '1);                          // null page
    send_word(CMD_SHARE, '0, '0);
    send_word(CMD_RELEASE, PN_W'(EXCLUDED_PAGE), '0);        // console page, never handed out
    send_word(CMD_SHARE, PN_W'(FIRST_USER_PAGE - 1), '0);    // below the user range
    send_word(CMD_NONE, TOP_PAGE, '1);                       // unused command
    send_word(CMD_ALLOC, '0, RB_W'(PAGE_BYTES));             // gets the released page back
    send_word(CMD_SHARE, TOP_PAGE - 1'b1, '0);
    send_word(CMD_RELEASE, TOP_PAGE - 2'd2, '0);
    send_word(CMD_ALLOC, '1, RB_W'(PAGE_BYTES / 2));
    send_word(CMD_SHARE, TOP_PAGE, '1);

    // drain the free list until allocation reports it empty, with some
    // oversized requests mixed in
    repeat (FILL_ALLOCS) begin
      if ($urandom_range(9) == 0) begin
        send_word(CMD_ALLOC, PN_W'($urandom()), RB_W'($urandom_range(PAGE_BYTES + 1, 65535)));
      end
      send_word(CMD_ALLOC, PN_W'($urandom()), RB_W'($urandom_range(0, PAGE_BYTES)));
    end

    // hold the sender off until every result is back
    cmd_if.valid <= 1'b0;
    wait (drained);
    @(negedge clk_i);

    // every user page is in use now: push one count into saturation
    sat_page = PN_W'($urandom_range(FIRST_USER_PAGE, PAGES - 1));
    repeat (int'(CNT_MAX) + 3) send_word(CMD_SHARE, sat_page, RB_W'($urandom()));

    // random traffic on user pages with some stray pages and unused commands
    repeat (MIXED_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_word(CMD_ALLOC, PN_W'($urandom()),
                  ($urandom_range(9) == 0) ? RB_W'($urandom())
                                           : RB_W'($urandom_range(0, PAGE_BYTES)));
      end else if (pick < 65) begin
        send_word(CMD_RELEASE, PN_W'($urandom_range(FIRST_USER_PAGE, PAGES - 1)),
                  RB_W'($urandom()));
      end else if (pick < 92) begin
        send_word(CMD_SHARE, PN_W'($urandom_range(FIRST_USER_PAGE, PAGES - 1)),
                  RB_W'($urandom()));
      end else if (pick < 97) begin
        send_word(($urandom_range(1) == 0) ? CMD_RELEASE : CMD_SHARE,
                  PN_W'($urandom_range(0, PAGES - 1)), RB_W'($urandom()));
      end else begin
        send_word(CMD_NONE, PN_W'($urandom()), RB_W'($urandom()));
      end
    end

    // wind down: let all results out, then idle before the verdict
    cmd_if.valid <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    wait (drained);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && drained) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
